FILE: design/nfmt_pkg.sv
// Shared types and constants for the number-to-ASCII formatter.
package nfmt_pkg;

  // Format selector codes
  localparam logic [1:0] ACT_DEC = 2'd0;
  localparam logic [1:0] ACT_HEX = 2'd1;
  localparam logic [1:0] ACT_BIN = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  // ASCII codes used by the formatter
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_UPPER = 8'h41;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // Digit counts per format
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned DEC_DIGS = 10;
  localparam int unsigned HEX_DIGS = 8;
  localparam int unsigned BCD_W    = 4 * DEC_DIGS;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } out_word_t;

endpackage

FILE: design/number_to_ascii_formatter.sv
// Number-to-ASCII formatter: converts a 32-bit word into a run of characters.
//
// Input channel (in_valid/in_ready/in_word): one word carries a format code
// (signed decimal, uppercase hex, binary) and a 32-bit value. Format code 3
// is dropped and gives no characters.
// Output channel (out_valid/out_ready/out_word): one character per word,
// most significant first, with last set on the final character of the run.
// Every format drops leading zeros; zero always gives a single '0'.
// Steps: decimal runs a shift-and-add-3 BCD conversion, one value bit per
// cycle, then skips suppressed leading zeros, emits a '-' for a negative
// value and emits the characters. Hex and binary start directly with the
// zero skip, one nibble or one bit per cycle.
// One word is in work at a time; in_ready rises as soon as the last
// character sits in the output register, so the next word overlaps its wait.
// A stalled receiver holds the output register and the run pauses there.
// Reset (synchronous, active low) empties the output and returns to idle.
module number_to_ascii_formatter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  nfmt_pkg::in_word_t in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output nfmt_pkg::out_word_t out_word
);
  import nfmt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [VAL_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0] dat_r, dat_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic [1:0]       mode_r, mode_nxt;
  logic             neg_r, neg_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_word_nxt;

  logic             can_load;
  logic [3:0]       nib;
  logic             top_zero;
  logic [7:0]       ch;
  logic [BCD_W-1:0] dat_adj;
  logic [BCD_W-1:0] dat_step;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign can_load  = !out_valid_r || out_ready;

  // Top digit of the data register and its character
  assign nib = dat_r[BCD_W-1 -: 4];
  always_comb begin
    if (mode_r == ACT_BIN) begin
      ch       = dat_r[BCD_W-1] ? CH_ONE : CH_ZERO;
      top_zero = !dat_r[BCD_W-1];
      dat_step = {dat_r[BCD_W-2:0], 1'b0};
    end else begin
      ch       = (nib > 4'd9) ? (CH_UPPER + {4'd0, nib} - 8'd10) : (CH_ZERO + {4'd0, nib});
      top_zero = (nib == 4'd0);
      dat_step = {dat_r[BCD_W-5:0], 4'd0};
    end
  end

  // Add-3 correction on every BCD digit before the shift
  always_comb begin
    for (int i = 0; i < DEC_DIGS; i++) begin
      dat_adj[4*i +: 4] = (dat_r[4*i +: 4] >= 4'd5) ? (dat_r[4*i +: 4] + 4'd3)
                                                      : dat_r[4*i +: 4];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    dat_nxt       = dat_r;
    cnt_nxt       = cnt_r;
    mode_nxt      = mode_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_word.action != ACT_NONE) begin
          mode_nxt = in_word.action;
          neg_nxt  = (in_word.action == ACT_DEC) && in_word.value[VAL_W-1];
          if (in_word.action == ACT_DEC) begin
            bin_nxt   = in_word.value[VAL_W-1] ? (32'd0 - in_word.value) : in_word.value;
            dat_nxt   = '0;
            cnt_nxt   = 6'(VAL_W);
            state_nxt = ST_CONV;
          end else begin
            dat_nxt   = {in_word.value, 8'd0};
            cnt_nxt   = (in_word.action == ACT_HEX) ? 6'(HEX_DIGS) : 6'(VAL_W);
            state_nxt = ST_SKIP;
          end
        end
      end
      ST_CONV: begin
        dat_nxt = {dat_adj[BCD_W-2:0], bin_r[VAL_W-1]};
        bin_nxt = {bin_r[VAL_W-2:0], 1'b0};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          cnt_nxt   = 6'(DEC_DIGS);
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zeros, keeping at least one digit
        if (top_zero && cnt_r > 6'd1) begin
          dat_nxt = dat_step;
          cnt_nxt = cnt_r - 6'd1;
        end else begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{char_code: CH_MINUS, last: 1'b0};
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{char_code: ch, last: (cnt_r == 6'd1)};
          dat_nxt       = dat_step;
          cnt_nxt       = cnt_r - 6'd1;
          if (cnt_r == 6'd1) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
    bin_r      <= bin_nxt;
    dat_r      <= dat_nxt;
    mode_r     <= mode_nxt;
    neg_r      <= neg_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the number-to-ASCII formatter: predicts every character run.
`timescale 1ns / 100ps

module testbench;
  import nfmt_pkg::*;

  localparam int unsigned       RANDOM_WORDS = 72;
  localparam int unsigned       HOLD_CYCLES  = 300;
  localparam int unsigned       DRAIN_CYCLES = 80;
  localparam int unsigned       MAX_REPORTS  = 40;
  localparam logic [31:0]       DEC_RADIX    = 32'd10;
  localparam logic [3:0]        HEX_MAX_DIG  = 4'd9;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  in_word_t    stim_q[$];
  out_word_t   char_q[$];
  int unsigned total_words = 0;
  int unsigned words_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_off = 1'b0;
  int unsigned mismatch_cnt = 0;
  int unsigned chars_checked = 0;
  int unsigned dec_runs = 0;
  int unsigned hex_runs = 0;
  int unsigned bin_runs = 0;
  int unsigned dropped_words = 0;
  int unsigned longest_run = 0;

  number_to_ascii_formatter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  always #5 clk = ~clk;

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
  endtask

  function automatic void queue_word(input logic [1:0] act, input logic [31:0] val);
    in_word_t w;
    w.action = act;
    w.value  = val;
    stim_q.push_back(w);
  endfunction

  // Expected characters for one accepted word, appended to char_q
  function automatic void format_number(input in_word_t w);
    logic [7:0]  text[$];
    logic [7:0]  digits[$];
    logic [31:0] mag;
    logic [31:0] rem;
    logic [3:0]  nib;
    logic        started;
    out_word_t   c;
    started = 1'b0;
    if (w.action == ACT_NONE) begin
      dropped_words++;
      return;
    end
    if (w.value == '0) begin
      text.push_back(CH_ZERO);
    end else if (w.action == ACT_DEC) begin
      mag = w.value;
      if (w.value[31]) begin
        text.push_back(CH_MINUS);
        mag = -w.value;
      end
      // least significant digit first, so build backwards
      while (mag != '0) begin
        rem = mag % DEC_RADIX;
        digits.push_front(CH_ZERO + rem[7:0]);
        mag = mag / DEC_RADIX;
      end
      foreach (digits[i]) text.push_back(digits[i]);
    end else if (w.action == ACT_HEX) begin
      for (int pos = 7; pos >= 0; pos--) begin
        nib = w.value[pos*4 +: 4];
        if (nib != '0) started = 1'b1;
        if (started) begin
          text.push_back(nib > HEX_MAX_DIG ? CH_UPPER + {4'd0, nib - 4'd10}
                                           : CH_ZERO + {4'd0, nib});
        end
      end
    end else begin
      for (int pos = 31; pos >= 0; pos--) begin
        if (w.value[pos]) started = 1'b1;
        if (started) text.push_back(w.value[pos] ? CH_ONE : CH_ZERO);
      end
    end
    case (w.action)
      ACT_DEC: dec_runs++;
      ACT_HEX: hex_runs++;
      default: bin_runs++;
    endcase
    if (text.size() > longest_run) longest_run = text.size();
    foreach (text[i]) begin
      c.char_code = text[i];
      c.last      = (i == text.size() - 1);
      char_q.push_back(c);
    end
  endfunction

  // Stimulus: directed corners, then random words of varied length
  initial begin
    int unsigned counted;
    logic [1:0]  act;
    logic [31:0] val;
    counted = 0;
    queue_word(ACT_DEC, 32'd0);
    queue_word(ACT_DEC, 32'd1);
    queue_word(ACT_DEC, 32'd9);
    queue_word(ACT_DEC, 32'd10);
    queue_word(ACT_DEC, 32'h7FFF_FFFF);
    queue_word(ACT_DEC, 32'h8000_0000);  // most negative: true magnitude
    queue_word(ACT_DEC, 32'hFFFF_FFFF);
    queue_word(ACT_DEC, 32'h4996_02D2);
    queue_word(ACT_DEC, 32'hFFFF_FFF6);
    queue_word(ACT_HEX, 32'd0);
    queue_word(ACT_HEX, 32'd1);
    queue_word(ACT_HEX, 32'h0000_000F);
    queue_word(ACT_HEX, 32'hFEDC_BA98);
    queue_word(ACT_HEX, 32'h0000_0010);
    queue_word(ACT_HEX, 32'hFFFF_FFFF);
    queue_word(ACT_BIN, 32'd0);
    queue_word(ACT_BIN, 32'd1);
    queue_word(ACT_BIN, 32'h8000_0000);  // bit 31 as plain bit
    queue_word(ACT_BIN, 32'hFFFF_FFFF);
    queue_word(ACT_BIN, 32'h0000_0100);
    queue_word(ACT_NONE, 32'd0);
    queue_word(ACT_NONE, 32'hFFFF_FFFF);
    while (counted < RANDOM_WORDS) begin
      case ($urandom_range(0, 3))
        0: val = $urandom;
        1: val = $urandom >> $urandom_range(1, 31);
        2: val = $urandom_range(0, 20);
        default: val = -$urandom_range(1, 1000);
      endcase
      if ($urandom_range(0, 11) == 0) begin
        act = ACT_NONE;
      end else begin
        case ($urandom_range(0, 2))
          0: act = ACT_DEC;
          1: act = ACT_HEX;
          default: act = ACT_BIN;
        endcase
        counted++;
      end
      queue_word(act, val);
    end
    total_words = stim_q.size();
  end

  // Driver: offers words from stim_q, idles per phase
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (words_sent < total_words / 3) begin
        send_idle_pct <= 26;
        recv_idle_pct <= 61;
      end else if (words_sent < 2 * total_words / 3) begin
        send_idle_pct <= 61;
        recv_idle_pct <= 26;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      if (!in_valid || in_ready) begin
        if (in_valid) begin
          format_number(in_word);
          words_sent++;
        end
        if (stim_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_word  <= stim_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each character word against the oldest expectation
  always @(posedge clk) begin : check_chars
    out_word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        chars_checked++;
        if (char_q.size() == 0) begin
          report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                    out_word.char_code, out_word.last));
        end else begin
          want = char_q.pop_front();
          if (out_word.char_code !== want.char_code) begin
            report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h",
                                      out_word.char_code, want.char_code));
          end
          if (out_word.last !== want.last) begin
            report_mismatch($sformatf("last %0b, expected %0b (char 0x%02h)",
                                      out_word.last, want.last, want.char_code));
          end
        end
      end
      out_ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Long receiver stall while the sender keeps offering, to back up the input
  initial begin
    wait (words_sent >= 30);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #3_000_000;
    $display("number_to_ascii_formatter regression: fail");
    $finish;
  end

  // End of run: drain, let stray output show, then report
  initial begin
    wait (total_words > 0 && rst_n);
    @(negedge clk);
    while (stim_q.size() > 0 || in_valid || char_q.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Words: %0d decimal, %0d hex, %0d binary, %0d dropped selector",
             dec_runs, hex_runs, bin_runs, dropped_words);
    $display("Characters checked: %0d, longest run %0d, mismatches %0d",
             chars_checked, longest_run, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("number_to_ascii_formatter regression: pass");
    end else begin
      $display("number_to_ascii_formatter regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/nfmt_pkg.sv
design/number_to_ascii_formatter.sv
bench/testbench.sv
